// ----- rtl/core/ubhe_pkg.sv -----
// Package: shared constants, phases and result types for the bootloader host engine.
`timescale 1ns / 1ps
package ubhe_pkg;

  localparam int BLOCK_BYTES_DEF = 256;
  localparam int MAX_RES = 5;
  localparam int RES_IDX_W = 3;

  localparam logic [2:0] CMD_INIT  = 3'd0;
  localparam logic [2:0] CMD_GET   = 3'd1;
  localparam logic [2:0] CMD_PROT  = 3'd2;
  localparam logic [2:0] CMD_ID    = 3'd3;
  localparam logic [2:0] CMD_READ  = 3'd4;
  localparam logic [2:0] CMD_WRITE = 3'd5;
  localparam logic [2:0] CMD_TGT   = 3'd6;
  localparam logic [2:0] CMD_HDAT  = 3'd7;

  localparam logic [7:0] SYNC_BYTE = 8'h7F;
  localparam logic [7:0] ACK_BYTE  = 8'h79;
  localparam logic [7:0] NACK_BYTE = 8'h1F;
  localparam logic [7:0] OP_GET    = 8'h00;
  localparam logic [7:0] OP_PROT   = 8'h01;
  localparam logic [7:0] OP_ID     = 8'h02;
  localparam logic [7:0] OP_READ   = 8'h11;
  localparam logic [7:0] OP_WRITE  = 8'h31;

  localparam logic [1:0] KIND_SEND  = 2'd0;
  localparam logic [1:0] KIND_REPLY = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_PROTO = 2'd1;
  localparam logic [1:0] ST_RDP   = 2'd2;
  localparam logic [1:0] ST_INVAL = 2'd3;

  localparam logic [4:0] PH_IDLE     = 5'd0;
  localparam logic [4:0] PH_CMD_ACK  = 5'd1;
  localparam logic [4:0] PH_GET_LEN  = 5'd2;
  localparam logic [4:0] PH_GET_VER  = 5'd3;
  localparam logic [4:0] PH_LIST     = 5'd4;
  localparam logic [4:0] PH_PRS_SKIP = 5'd5;
  localparam logic [4:0] PH_PRS_D    = 5'd6;
  localparam logic [4:0] PH_PRS_E    = 5'd7;
  localparam logic [4:0] PH_FINAL    = 5'd8;
  localparam logic [4:0] PH_ID_LEN   = 5'd9;
  localparam logic [4:0] PH_MEM_CMD  = 5'd10;
  localparam logic [4:0] PH_MEM_ADDR = 5'd11;
  localparam logic [4:0] PH_RD_CNT   = 5'd12;
  localparam logic [4:0] PH_RD_DATA  = 5'd13;
  localparam logic [4:0] PH_WR_DATA  = 5'd14;
  localparam logic [4:0] PH_WR_ACK   = 5'd15;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic [1:0] status;
  } res_t;

  typedef struct packed {
    logic [RES_IDX_W-1:0] cnt;
    res_t [MAX_RES-1:0]   res;
  } res_list_t;

  typedef struct packed {
    logic [4:0]  phase;
    logic [2:0]  operation;
    logic [31:0] cur_addr;
    logic [23:0] bytes_rem;
    logic [8:0]  block_left;
    logic [7:0]  run_xor;
    logic [8:0]  reply_left;
  } eng_state_t;

endpackage

// ----- rtl/core/ubhe_step.sv -----
// Combinational step: one input item against engine state, gives next state and results.
`timescale 1ns / 1ps
module ubhe_step #(
  parameter int BLOCK_BYTES = ubhe_pkg::BLOCK_BYTES_DEF
) (
  input  ubhe_pkg::eng_state_t st,
  input  logic [7:0]           reply_cap,
  input  logic [2:0]           cmd,
  input  logic [31:0]          base_addr,
  input  logic [23:0]          byte_count,
  input  logic [7:0]           data_byte,
  output ubhe_pkg::eng_state_t st_nxt,
  output ubhe_pkg::res_list_t  rl
);
  import ubhe_pkg::*;

  localparam logic [23:0] BLK24 = 24'(BLOCK_BYTES);

  always_comb begin
    logic [7:0]  b;
    logic [31:0] a;
    logic [8:0]  blk;
    logic [7:0]  c;
    logic [8:0]  rl_dec;
    logic [8:0]  bl_dec;
    logic [7:0]  xr;
    b = data_byte;
    a = st.cur_addr;
    blk = '0;
    c = '0;
    rl_dec = st.reply_left - 9'd1;
    bl_dec = st.block_left - 9'd1;
    xr = st.run_xor ^ b;
    st_nxt = st;
    rl = '0;

    // results are appended in order; res[cnt] gets the next one
    if (cmd == CMD_TGT) begin
      case (st.phase)
        PH_FINAL: begin
          st_nxt.phase = PH_IDLE;
          rl.res[0] = '{KIND_DONE, 8'd0, (b == ACK_BYTE) ? ST_OK : ST_PROTO};
          rl.cnt = 3'd1;
        end
        PH_CMD_ACK: begin
          if (b != ACK_BYTE) begin
            st_nxt.phase = PH_IDLE;
            rl.res[0] = '{KIND_DONE, 8'd0, ST_PROTO};
            rl.cnt = 3'd1;
          end else begin
            st_nxt.phase = (st.operation == CMD_GET) ? PH_GET_LEN :
                           (st.operation == CMD_PROT) ? PH_PRS_SKIP : PH_ID_LEN;
          end
        end
        PH_GET_LEN: begin
          st_nxt.reply_left = {1'b0, b};
          st_nxt.phase = PH_GET_VER;
        end
        PH_GET_VER: begin
          if ({1'b0, reply_cap} < st.reply_left) begin
            st_nxt.phase = PH_IDLE;
            rl.res[0] = '{KIND_DONE, 8'd0, ST_INVAL};
            rl.cnt = 3'd1;
          end else begin
            st_nxt.phase = (st.reply_left == 9'd0) ? PH_FINAL : PH_LIST;
          end
        end
        PH_ID_LEN: begin
          st_nxt.reply_left = {1'b0, b} + 9'd1;
          if ({1'b0, reply_cap} < ({1'b0, b} + 9'd1)) begin
            st_nxt.phase = PH_IDLE;
            rl.res[0] = '{KIND_DONE, 8'd0, ST_INVAL};
            rl.cnt = 3'd1;
          end else begin
            st_nxt.phase = PH_LIST;
          end
        end
        PH_LIST: begin
          st_nxt.reply_left = rl_dec;
          if (rl_dec == 9'd0) st_nxt.phase = PH_FINAL;
          rl.res[0] = '{KIND_REPLY, b, ST_OK};
          rl.cnt = 3'd1;
        end
        PH_PRS_SKIP: st_nxt.phase = PH_PRS_D;
        PH_PRS_D: begin
          st_nxt.phase = PH_PRS_E;
          rl.res[0] = '{KIND_REPLY, b, ST_OK};
          rl.cnt = 3'd1;
        end
        PH_PRS_E: begin
          st_nxt.phase = PH_FINAL;
          rl.res[0] = '{KIND_REPLY, b, ST_OK};
          rl.cnt = 3'd1;
        end
        PH_MEM_CMD: begin
          if (b == NACK_BYTE || b != ACK_BYTE) begin
            st_nxt.phase = PH_IDLE;
            rl.res[0] = '{KIND_DONE, 8'd0, (b == NACK_BYTE) ? ST_RDP : ST_PROTO};
            rl.cnt = 3'd1;
          end else begin
            rl.res[0] = '{KIND_SEND, a[31:24], ST_OK};
            rl.res[1] = '{KIND_SEND, a[23:16], ST_OK};
            rl.res[2] = '{KIND_SEND, a[15:8], ST_OK};
            rl.res[3] = '{KIND_SEND, a[7:0], ST_OK};
            rl.res[4] = '{KIND_SEND, a[31:24] ^ a[23:16] ^ a[15:8] ^ a[7:0], ST_OK};
            rl.cnt = 3'd5;
            st_nxt.phase = PH_MEM_ADDR;
          end
        end
        PH_MEM_ADDR: begin
          if (b != ACK_BYTE) begin
            st_nxt.phase = PH_IDLE;
            rl.res[0] = '{KIND_DONE, 8'd0, (b == NACK_BYTE) ? ST_INVAL : ST_PROTO};
            rl.cnt = 3'd1;
          end else begin
            blk = (st.bytes_rem >= BLK24) ? 9'(BLOCK_BYTES) : st.bytes_rem[8:0];
            c = 8'(blk - 9'd1);
            st_nxt.block_left = blk;
            rl.res[0] = '{KIND_SEND, c, ST_OK};
            if (st.operation == CMD_WRITE) begin
              st_nxt.run_xor = c;
              st_nxt.phase = PH_WR_DATA;
              rl.cnt = 3'd1;
            end else begin
              rl.res[1] = '{KIND_SEND, ~c, ST_OK};
              rl.cnt = 3'd2;
              st_nxt.phase = PH_RD_CNT;
            end
          end
        end
        PH_RD_CNT: begin
          if (b != ACK_BYTE) begin
            st_nxt.phase = PH_IDLE;
            rl.res[0] = '{KIND_DONE, 8'd0, (b == NACK_BYTE) ? ST_RDP : ST_PROTO};
            rl.cnt = 3'd1;
          end else begin
            st_nxt.phase = PH_RD_DATA;
          end
        end
        PH_RD_DATA: begin
          rl.res[0] = '{KIND_REPLY, b, ST_OK};
          rl.cnt = 3'd1;
          st_nxt.cur_addr = a + 32'd1;
          st_nxt.bytes_rem = st.bytes_rem - 24'd1;
          st_nxt.block_left = bl_dec;
          if (bl_dec == 9'd0) begin
            if (st.bytes_rem == 24'd1) begin
              st_nxt.phase = PH_IDLE;
              rl.res[1] = '{KIND_DONE, 8'd0, ST_OK};
              rl.cnt = 3'd2;
            end else begin
              // read block restart: address alignment does not matter
              rl.res[1] = '{KIND_SEND, OP_READ, ST_OK};
              rl.res[2] = '{KIND_SEND, ~OP_READ, ST_OK};
              rl.cnt = 3'd3;
              st_nxt.phase = PH_MEM_CMD;
            end
          end
        end
        PH_WR_ACK: begin
          if (b != ACK_BYTE) begin
            st_nxt.phase = PH_IDLE;
            rl.res[0] = '{KIND_DONE, 8'd0, ST_PROTO};
            rl.cnt = 3'd1;
          end else if (st.bytes_rem == 24'd0) begin
            st_nxt.phase = PH_IDLE;
            rl.res[0] = '{KIND_DONE, 8'd0, ST_OK};
            rl.cnt = 3'd1;
          end else if (a[1:0] != 2'd0) begin
            st_nxt.phase = PH_IDLE;
            rl.res[0] = '{KIND_DONE, 8'd0, ST_INVAL};
            rl.cnt = 3'd1;
          end else begin
            rl.res[0] = '{KIND_SEND, OP_WRITE, ST_OK};
            rl.res[1] = '{KIND_SEND, ~OP_WRITE, ST_OK};
            rl.cnt = 3'd2;
            st_nxt.phase = PH_MEM_CMD;
          end
        end
        default: ;
      endcase
    end else if (cmd == CMD_HDAT) begin
      if (st.phase == PH_WR_DATA) begin
        rl.res[0] = '{KIND_SEND, b, ST_OK};
        rl.cnt = 3'd1;
        st_nxt.run_xor = xr;
        st_nxt.cur_addr = a + 32'd1;
        st_nxt.bytes_rem = st.bytes_rem - 24'd1;
        st_nxt.block_left = bl_dec;
        if (bl_dec == 9'd0) begin
          rl.res[1] = '{KIND_SEND, xr, ST_OK};
          rl.cnt = 3'd2;
          st_nxt.phase = PH_WR_ACK;
        end
      end
    end else if (st.phase == PH_IDLE) begin
      st_nxt.operation = cmd;
      case (cmd)
        CMD_INIT: begin
          rl.res[0] = '{KIND_SEND, SYNC_BYTE, ST_OK};
          rl.cnt = 3'd1;
          st_nxt.phase = PH_FINAL;
        end
        CMD_GET, CMD_PROT, CMD_ID: begin
          c = (cmd == CMD_GET) ? OP_GET : (cmd == CMD_PROT) ? OP_PROT : OP_ID;
          rl.res[0] = '{KIND_SEND, c, ST_OK};
          rl.res[1] = '{KIND_SEND, ~c, ST_OK};
          rl.cnt = 3'd2;
          st_nxt.phase = PH_CMD_ACK;
        end
        default: begin
          st_nxt.cur_addr = base_addr;
          st_nxt.bytes_rem = byte_count;
          if (byte_count == 24'd0) begin
            st_nxt.phase = PH_IDLE;
            rl.res[0] = '{KIND_DONE, 8'd0, ST_OK};
            rl.cnt = 3'd1;
          end else if (cmd == CMD_WRITE && base_addr[1:0] != 2'd0) begin
            st_nxt.phase = PH_IDLE;
            rl.res[0] = '{KIND_DONE, 8'd0, ST_INVAL};
            rl.cnt = 3'd1;
          end else begin
            c = (cmd == CMD_WRITE) ? OP_WRITE : OP_READ;
            rl.res[0] = '{KIND_SEND, c, ST_OK};
            rl.res[1] = '{KIND_SEND, ~c, ST_OK};
            rl.cnt = 3'd2;
            st_nxt.phase = PH_MEM_CMD;
          end
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/ubhe_outq.sv -----
// Result buffer: holds one item's result list and drains it one result per cycle while out_tready is high.
`timescale 1ns / 1ps
module ubhe_outq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  ubhe_pkg::res_list_t load_list,
  output logic                busy,
  output logic                drain_last,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [15:0]         out_tdata,
  output logic [1:0]          out_tuser,
  output logic                out_tlast
);
  import ubhe_pkg::*;

  res_list_t          list_r;
  logic [RES_IDX_W-1:0] idx_r, idx_nxt, cnt_r, cnt_nxt;
  res_t               cur;

  assign busy = (cnt_r != '0);
  assign out_tvalid = busy;
  assign cur = list_r.res[idx_r];
  assign out_tdata = {6'd0, cur.status, cur.value};
  assign out_tuser = cur.kind;
  assign out_tlast = (idx_r + 3'd1 == cnt_r);
  assign drain_last = out_tvalid && out_tready && out_tlast;

  always_comb begin
    idx_nxt = idx_r;
    cnt_nxt = cnt_r;
    if (out_tvalid && out_tready) begin
      if (out_tlast) begin
        cnt_nxt = '0;
        idx_nxt = '0;
      end else begin
        idx_nxt = idx_r + 3'd1;
      end
    end
    if (load) begin
      cnt_nxt = load_list.cnt;
      idx_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      idx_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      idx_r <= idx_nxt;
    end
    if (load) list_r <= load_list;
  end

endmodule

// ----- rtl/core/uart_bootloader_host_engine_unit.sv -----
// Top level: bootloader host engine with input register, step logic and result buffer.
`timescale 1ns / 1ps
// An accepted item is held in the input register; once the result buffer is free or drains
//   its last result, the item's results are registered there and shown on the output.
// Throughput: one item per cycle when items cause no result and the buffer is free; an item
//   with results holds the next item in the input register while they drain, out_tready stalls included.
// Reset (rst_n low, synchronous): phase idle, all counters zero, reply_capacity 255,
//   input register and result buffer empty.
module uart_bootloader_host_engine_unit #(
  parameter int BLOCK_BYTES = ubhe_pkg::BLOCK_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // tuser: cmd[2:0]
  input  logic [2:0]  in_tuser,
  // tdata: base address[31:0], byte_count[55:32], data_byte[63:56]
  input  logic [63:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // tuser: kind[1:0]
  output logic [1:0]  out_tuser,
  // tdata: value[7:0], status[9:8], zero pad
  output logic [15:0] out_tdata,
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);
  import ubhe_pkg::*;

  logic        vld_r;
  logic [66:0] item_r;
  logic [7:0]  cap_r;
  eng_state_t  st_r, st_nxt;
  res_list_t   rl;
  logic        q_busy, q_drain_last, step_go, load;

  assign cfg_ready = 1'b1;

  // the registered item is evaluated once the buffer is free or drains this cycle
  assign step_go = vld_r && (!q_busy || q_drain_last);
  assign load = step_go && (rl.cnt != '0);
  assign in_tready = !vld_r || step_go;

  // item_r: cmd[2:0], address[34:3], count[58:35], byte[66:59]
  ubhe_step #(.BLOCK_BYTES(BLOCK_BYTES)) u_step (
    .st(st_r), .reply_cap(cap_r),
    .cmd(item_r[2:0]), .base_addr(item_r[34:3]),
    .byte_count(item_r[58:35]), .data_byte(item_r[66:59]),
    .st_nxt(st_nxt), .rl(rl)
  );

  ubhe_outq u_outq (
    .clk(clk), .rst_n(rst_n), .load(load), .load_list(rl),
    .busy(q_busy), .drain_last(q_drain_last),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      cap_r <= 8'hFF;
      st_r  <= '0;
    end else begin
      if (cfg_valid) cap_r <= cfg_data;
      if (in_tready) vld_r <= in_tvalid;
      if (step_go) st_r <= st_nxt;
    end
    if (in_tready && in_tvalid) item_r <= {in_tdata, in_tuser};
  end

  a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !vld_r |-> in_tready) else $error("input register empty but not ready");
  a_drain_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> out_tvalid) else $error("loaded result list not shown");
  a_phase_rng: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.phase[4] == 1'b0) else $error("phase out of range");

endmodule
